### hdl/euler_yxz_to_rotation_matrix_top_macros.svh
// Assertion macros used by the top module of the Euler to matrix block.
`ifndef EULER_YXZ_TO_ROTATION_MATRIX_TOP_MACROS_SVH
`define EULER_YXZ_TO_ROTATION_MATRIX_TOP_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define EYXZ_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("eyxz assertion failed");

// A condition that implies another at the next clock edge.
`define EYXZ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eyxz assertion failed");

`endif

### hdl/eyxz_pkg.sv
package eyxz_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 14;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 16;

    // Quarter-wave phase and series arithmetic widths.
    localparam int UFRAC   = ANGLE_BITS - 2;
    localparam int U_W     = UFRAC + 1;
    localparam int Q30     = 30;
    localparam int X_W     = 31;
    localparam int ACC_W   = 31;
    localparam int PROD_W  = 2 * X_W;
    localparam int TERMS   = 8;
    localparam int HORNER  = TERMS - 1;

    // Signed sine, cosine and matrix entry width.
    localparam int SC_W = FRAC_BITS + 2;

    // Pipeline depths.
    localparam int SINE_STAGES = HORNER + 2;
    localparam int SC_STAGES   = SINE_STAGES + 1;
    localparam int MIX_STAGES  = 3;
    localparam int LAT         = SC_STAGES + MIX_STAGES;

    localparam logic [U_W-1:0]    QUARTER     = U_W'(1) << UFRAC;
    localparam logic signed [SC_W-1:0] ONE    = SC_W'(1) << FRAC_BITS;
    localparam logic signed [OUT_W-1:0] ONE_OUT = OUT_W'(ONE);
    localparam longint unsigned   HALF_PI_Q30 = 64'd1686629713;

    // Taylor coefficients of sin(pi/2 * x) in unsigned Q30. Each term is the
    // previous one times (pi/2)^2 over (k+1)(k+2), rounded half up at each step.
    localparam longint unsigned Q30_HALF    = 64'd1 << (Q30 - 1);
    localparam longint unsigned HALF_PI_SQ  = (HALF_PI_Q30 * HALF_PI_Q30 + Q30_HALF) >> Q30;
    localparam longint unsigned SERIES_C0   = HALF_PI_Q30;
    localparam longint unsigned SERIES_T1   = (SERIES_C0 * HALF_PI_SQ + Q30_HALF) >> Q30;
    localparam longint unsigned SERIES_C1   = (SERIES_T1 + 64'd3) / 64'd6;
    localparam longint unsigned SERIES_T2   = (SERIES_C1 * HALF_PI_SQ + Q30_HALF) >> Q30;
    localparam longint unsigned SERIES_C2   = (SERIES_T2 + 64'd10) / 64'd20;
    localparam longint unsigned SERIES_T3   = (SERIES_C2 * HALF_PI_SQ + Q30_HALF) >> Q30;
    localparam longint unsigned SERIES_C3   = (SERIES_T3 + 64'd21) / 64'd42;
    localparam longint unsigned SERIES_T4   = (SERIES_C3 * HALF_PI_SQ + Q30_HALF) >> Q30;
    localparam longint unsigned SERIES_C4   = (SERIES_T4 + 64'd36) / 64'd72;
    localparam longint unsigned SERIES_T5   = (SERIES_C4 * HALF_PI_SQ + Q30_HALF) >> Q30;
    localparam longint unsigned SERIES_C5   = (SERIES_T5 + 64'd55) / 64'd110;
    localparam longint unsigned SERIES_T6   = (SERIES_C5 * HALF_PI_SQ + Q30_HALF) >> Q30;
    localparam longint unsigned SERIES_C6   = (SERIES_T6 + 64'd78) / 64'd156;
    localparam longint unsigned SERIES_T7   = (SERIES_C6 * HALF_PI_SQ + Q30_HALF) >> Q30;
    localparam longint unsigned SERIES_C7   = (SERIES_T7 + 64'd105) / 64'd210;

    typedef struct packed {
        logic signed [IN_W-1:0] angle_x;
        logic signed [IN_W-1:0] angle_y;
        logic signed [IN_W-1:0] angle_z;
    } angles_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] m00;
        logic signed [OUT_W-1:0] m01;
        logic signed [OUT_W-1:0] m02;
        logic signed [OUT_W-1:0] m10;
        logic signed [OUT_W-1:0] m11;
        logic signed [OUT_W-1:0] m12;
        logic signed [OUT_W-1:0] m20;
        logic signed [OUT_W-1:0] m21;
        logic signed [OUT_W-1:0] m22;
    } matrix_t;

    // Taylor coefficient of sin(pi/2 * x), term idx, unsigned Q30.
    function automatic logic [ACC_W-1:0] series_coeff(input int idx);
        logic [ACC_W-1:0] c;
        case (idx)
            0:       c = ACC_W'(SERIES_C0);
            1:       c = ACC_W'(SERIES_C1);
            2:       c = ACC_W'(SERIES_C2);
            3:       c = ACC_W'(SERIES_C3);
            4:       c = ACC_W'(SERIES_C4);
            5:       c = ACC_W'(SERIES_C5);
            6:       c = ACC_W'(SERIES_C6);
            default: c = ACC_W'(SERIES_C7);
        endcase
        return c;
    endfunction

    // Product in Q60 rounded half up back to Q30.
    function automatic logic [ACC_W-1:0] rnd_q30(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] s;
        s = {1'b0, p} + ((PROD_W + 1)'(1) << (Q30 - 1));
        return s[Q30+ACC_W-1:Q30];
    endfunction

    // Fixed-point product rounded half away from zero.
    function automatic logic signed [SC_W-1:0] fmul(input logic signed [SC_W-1:0] a,
                                                    input logic signed [SC_W-1:0] b);
        logic signed [2*SC_W-1:0] p;
        logic [2*SC_W-1:0] mag;
        logic [2*SC_W-1:0] m;
        p   = a * b;
        mag = p[2*SC_W-1] ? (2*SC_W)'(-p) : (2*SC_W)'(p);
        m   = (mag + ((2*SC_W)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return p[2*SC_W-1] ? -m[SC_W-1:0] : m[SC_W-1:0];
    endfunction

    // Clamp a sum to plus or minus one and size it for the port.
    function automatic logic signed [OUT_W-1:0] sat(input logic signed [SC_W:0] v);
        logic signed [SC_W:0] c;
        if (v > (SC_W + 1)'(ONE)) begin
            c = (SC_W + 1)'(ONE);
        end
        else if (v < -(SC_W + 1)'(ONE)) begin
            c = -(SC_W + 1)'(ONE);
        end
        else begin
            c = v;
        end
        return OUT_W'(c);
    endfunction

endpackage

### hdl/eyxz_qsine.sv
module eyxz_qsine (
    input  logic                        clk,
    input  logic                        advance,
    input  logic [eyxz_pkg::U_W-1:0]    u,
    output logic [eyxz_pkg::ACC_W-1:0]  s30
);
    import eyxz_pkg::*;

    logic [X_W-1:0]   x_in;
    logic [PROD_W-1:0] sq;
    logic [X_W-1:0]   x_reg   [0:HORNER];
    logic [ACC_W-1:0] x2_reg  [0:HORNER];
    logic [ACC_W-1:0] acc_reg [0:HORNER];
    logic [ACC_W-1:0] s_reg;

    // Phase as Q30 fraction of a quarter turn, and its square.
    assign x_in = {u, {(32 - ANGLE_BITS){1'b0}}};
    assign sq   = PROD_W'(x_in) * PROD_W'(x_in);

    always_ff @(posedge clk) begin
        if (advance) begin
            x_reg[0]   <= x_in;
            x2_reg[0]  <= rnd_q30(sq);
            acc_reg[0] <= series_coeff(HORNER);
        end
    end

    // One Horner step per stage, highest term first.
    for (genvar j = 1; j <= HORNER; j++) begin : g_horner
        localparam logic [ACC_W-1:0] CJ = series_coeff(HORNER - j);
        logic [ACC_W-1:0] t;
        assign t = rnd_q30(PROD_W'(x2_reg[j-1]) * PROD_W'(acc_reg[j-1]));
        always_ff @(posedge clk) begin
            if (advance) begin
                x_reg[j]   <= x_reg[j-1];
                x2_reg[j]  <= x2_reg[j-1];
                acc_reg[j] <= (t > CJ) ? '0 : CJ - t;
            end
        end
    end

    // Final multiply by the phase.
    always_ff @(posedge clk) begin
        if (advance) begin
            s_reg <= rnd_q30(PROD_W'(x_reg[HORNER]) * PROD_W'(acc_reg[HORNER]));
        end
    end

    assign s30 = s_reg;

endmodule

### hdl/eyxz_sincos.sv
module eyxz_sincos (
    input  logic                              clk,
    input  logic                              advance,
    input  logic [eyxz_pkg::IN_W-1:0]         angle,
    output logic signed [eyxz_pkg::SC_W-1:0]  sn,
    output logic signed [eyxz_pkg::SC_W-1:0]  cs
);
    import eyxz_pkg::*;

    logic [U_W-1:0]   u_r;
    logic [U_W-1:0]   u_c;
    logic [1:0]       quad;
    logic [ACC_W-1:0] sr30;
    logic [ACC_W-1:0] sc30;
    logic [1:0]       quad_reg [0:SINE_STAGES-1];
    logic signed [SC_W-1:0] sr;
    logic signed [SC_W-1:0] sc;
    logic signed [SC_W-1:0] sn_next;
    logic signed [SC_W-1:0] cs_next;
    logic signed [SC_W-1:0] sn_reg;
    logic signed [SC_W-1:0] cs_reg;

    // Split the wrapped angle into quadrant and phase.
    assign quad = angle[ANGLE_BITS-1 -: 2];
    assign u_r  = {1'b0, angle[UFRAC-1:0]};
    assign u_c  = QUARTER - u_r;

    eyxz_qsine u_sine_r (.clk(clk), .advance(advance), .u(u_r), .s30(sr30));
    eyxz_qsine u_sine_c (.clk(clk), .advance(advance), .u(u_c), .s30(sc30));

    // Quadrant travels alongside the series pipelines.
    always_ff @(posedge clk) begin
        if (advance) begin
            quad_reg[0] <= quad;
            for (int i = 1; i < SINE_STAGES; i++) begin
                quad_reg[i] <= quad_reg[i-1];
            end
        end
    end

    // Round to the output fraction and clamp to one.
    function automatic logic signed [SC_W-1:0] finish(input logic [ACC_W-1:0] v);
        logic [ACC_W:0] s;
        s = ({1'b0, v} + ((ACC_W + 1)'(1) << (Q30 - FRAC_BITS - 1))) >> (Q30 - FRAC_BITS);
        return (s > (ACC_W + 1)'(ONE)) ? ONE : SC_W'(s);
    endfunction

    assign sr = finish(sr30);
    assign sc = finish(sc30);

    // Place the quarter-wave values by quadrant.
    always_comb begin
        case (quad_reg[SINE_STAGES-1])
            2'd0:
            begin
                sn_next = sr;
                cs_next = sc;
            end
            2'd1:
            begin
                sn_next = sc;
                cs_next = -sr;
            end
            2'd2:
            begin
                sn_next = -sr;
                cs_next = -sc;
            end
            default:
            begin
                sn_next = -sc;
                cs_next = sr;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            sn_reg <= sn_next;
            cs_reg <= cs_next;
        end
    end

    assign sn = sn_reg;
    assign cs = cs_reg;

endmodule

### hdl/eyxz_mix.sv
module eyxz_mix (
    input  logic                              clk,
    input  logic                              advance,
    input  logic signed [eyxz_pkg::SC_W-1:0]  sx,
    input  logic signed [eyxz_pkg::SC_W-1:0]  cx,
    input  logic signed [eyxz_pkg::SC_W-1:0]  sy,
    input  logic signed [eyxz_pkg::SC_W-1:0]  cy,
    input  logic signed [eyxz_pkg::SC_W-1:0]  sz,
    input  logic signed [eyxz_pkg::SC_W-1:0]  cz,
    output eyxz_pkg::matrix_t                 matrix
);
    import eyxz_pkg::*;

    logic signed [SC_W-1:0] cycz_reg, sxsy_reg, czsx_reg, cysz_reg, cxsy_reg, cxsz_reg;
    logic signed [SC_W-1:0] cxcz_reg, cysx_reg, czsy_reg, sysz_reg, cxcy_reg;
    logic signed [SC_W-1:0] sx1_reg, sy1_reg, sz1_reg;
    logic signed [SC_W-1:0] sxsysz_reg, czsxsy_reg, cysxsz_reg, cyczsx_reg;
    logic signed [SC_W-1:0] cycz2_reg, cysz2_reg, cxsy2_reg, cxsz2_reg, cxcz2_reg;
    logic signed [SC_W-1:0] czsy2_reg, sysz2_reg, cxcy2_reg, sx2_reg;
    matrix_t                matrix_reg;

    // Two-factor products.
    always_ff @(posedge clk) begin
        if (advance) begin
            cycz_reg <= fmul(cy, cz);
            sxsy_reg <= fmul(sx, sy);
            czsx_reg <= fmul(cz, sx);
            cysz_reg <= fmul(cy, sz);
            cxsy_reg <= fmul(cx, sy);
            cxsz_reg <= fmul(cx, sz);
            cxcz_reg <= fmul(cx, cz);
            cysx_reg <= fmul(cy, sx);
            czsy_reg <= fmul(cz, sy);
            sysz_reg <= fmul(sy, sz);
            cxcy_reg <= fmul(cx, cy);
            sx1_reg  <= sx;
            sy1_reg  <= sy;
            sz1_reg  <= sz;
        end
    end

    // Third factors, left to right.
    always_ff @(posedge clk) begin
        if (advance) begin
            sxsysz_reg <= fmul(sxsy_reg, sz1_reg);
            czsxsy_reg <= fmul(czsx_reg, sy1_reg);
            cysxsz_reg <= fmul(cysx_reg, sz1_reg);
            cyczsx_reg <= fmul(cycz_reg, sx1_reg);
            cycz2_reg  <= cycz_reg;
            cysz2_reg  <= cysz_reg;
            cxsy2_reg  <= cxsy_reg;
            cxsz2_reg  <= cxsz_reg;
            cxcz2_reg  <= cxcz_reg;
            czsy2_reg  <= czsy_reg;
            sysz2_reg  <= sysz_reg;
            cxcy2_reg  <= cxcy_reg;
            sx2_reg    <= sx1_reg;
        end
    end

    // Sums, saturation and the output register.
    always_ff @(posedge clk) begin
        if (advance) begin
            matrix_reg.m00 <= sat((SC_W + 1)'(cycz2_reg) + (SC_W + 1)'(sxsysz_reg));
            matrix_reg.m01 <= sat((SC_W + 1)'(czsxsy_reg) - (SC_W + 1)'(cysz2_reg));
            matrix_reg.m02 <= sat((SC_W + 1)'(cxsy2_reg));
            matrix_reg.m10 <= sat((SC_W + 1)'(cxsz2_reg));
            matrix_reg.m11 <= sat((SC_W + 1)'(cxcz2_reg));
            matrix_reg.m12 <= sat(-(SC_W + 1)'(sx2_reg));
            matrix_reg.m20 <= sat((SC_W + 1)'(cysxsz_reg) - (SC_W + 1)'(czsy2_reg));
            matrix_reg.m21 <= sat((SC_W + 1)'(cyczsx_reg) + (SC_W + 1)'(sysz2_reg));
            matrix_reg.m22 <= sat((SC_W + 1)'(cxcy2_reg));
        end
    end

    assign matrix = matrix_reg;

endmodule

### hdl/euler_yxz_to_rotation_matrix_top.sv
// The pipeline has 13 stages: nine series stages, one quadrant stage and three
// product stages.
// Throughput: one item per cycle while the output is not stalled; six quarter-wave
// series pipelines (two per angle) and one product pipeline, all fully pipelined.
// A stalled output freezes the whole pipeline, so the input stalls with it.
// Reset clears only the stage valid flags; the data registers are not reset.
`include "euler_yxz_to_rotation_matrix_top_macros.svh"

module euler_yxz_to_rotation_matrix_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              angles_valid,
    output logic              angles_stall,
    input  eyxz_pkg::angles_t angles,
    output logic              matrix_valid,
    input  logic              matrix_stall,
    output eyxz_pkg::matrix_t matrix
);
    import eyxz_pkg::*;

    logic                   advance;
    logic [LAT-1:0]         vld_reg;
    logic [LAT-1:0]         vld_next;
    logic signed [SC_W-1:0] sx, cx, sy, cy, sz, cz;

    // The pipeline moves unless a finished matrix is held by the sink.
    assign advance      = !(vld_reg[LAT-1] && matrix_stall);
    assign angles_stall = !advance;
    assign matrix_valid = vld_reg[LAT-1];

    always_comb begin
        vld_next = advance ? {vld_reg[LAT-2:0], angles_valid} : vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            vld_reg <= vld_next;
        end
    end

    // One sine/cosine lane per axis.
    eyxz_sincos u_lane_x (.clk(clk), .advance(advance), .angle(angles.angle_x),
                          .sn(sx), .cs(cx));
    eyxz_sincos u_lane_y (.clk(clk), .advance(advance), .angle(angles.angle_y),
                          .sn(sy), .cs(cy));
    eyxz_sincos u_lane_z (.clk(clk), .advance(advance), .angle(angles.angle_z),
                          .sn(sz), .cs(cz));

    // Merge the lanes into the nine entries.
    eyxz_mix u_mix (
        .clk(clk), .advance(advance),
        .sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz),
        .matrix(matrix)
    );

    `EYXZ_ASSERT_NEXT(a_drain, vld_reg[LAT-2] && advance, matrix_valid)
    `EYXZ_ASSERT_NEXT(a_freeze, !advance, $stable(vld_reg))
    `EYXZ_ASSERT_ALWAYS(a_m00, !matrix_valid || (matrix.m00 <= ONE_OUT && matrix.m00 >= -ONE_OUT))
    `EYXZ_ASSERT_ALWAYS(a_m12, !matrix_valid || (matrix.m12 <= ONE_OUT && matrix.m12 >= -ONE_OUT))

endmodule
